/* rtl/multitrack_midi_event_merger_macros.svh */
// Assertion macros shared by the RTL of the event merger
`ifndef MULTITRACK_MIDI_EVENT_MERGER_MACROS_SVH
`define MULTITRACK_MIDI_EVENT_MERGER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define MMEM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("merger assertion failed");

// Next-cycle implication, checked outside reset
`define MMEM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("merger assertion failed");

`endif

/* rtl/mmem_pkg.sv */
package mmem_pkg;

    // Request modes
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_NEXT   = 2'd1;
    localparam logic [1:0] MODE_REWIND = 2'd2;

    // Result status codes
    localparam logic [1:0] RES_OK  = 2'd0;
    localparam logic [1:0] RES_EOF = 2'd1;
    localparam logic [1:0] RES_BAD = 2'd2;

    // Byte codes
    localparam logic [7:0] CHAN_CMD_MIN = 8'h80;
    localparam logic [7:0] SYSEX_CMD    = 8'hF0;
    localparam logic [7:0] META_CMD     = 8'hFF;
    localparam logic [7:0] META_EOT     = 8'h2F;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_REC,
        ST_REW_REC,
        ST_SC_REC,
        ST_SC_DLT,
        ST_SC_FF,
        ST_SC_EOT,
        ST_PK_REC,
        ST_PK_CMD,
        ST_PK_D1,
        ST_PK_D2,
        ST_PK_TYPE,
        ST_PK_SIZE,
        ST_DONE
    } state_t;

    // Channel messages with two data bytes (all but program change and channel pressure)
    function automatic logic msg_two_data(input logic [7:0] cmd);
        logic r;
        case (cmd[7:4])
            4'hC, 4'hD: r = 1'b0;
            default:    r = 1'b1;
        endcase
        return r;
    endfunction

endpackage

/* rtl/multitrack_midi_event_merger.sv */
// Multitrack MIDI event merger. Track bytes are loaded one request at a time into a byte store
// (TRACKS regions of TRACK_BYTES each, contents undefined until loaded); per-track length,
// position, remaining count and time sit in a small table memory whose entries read as zero
// until first written. A next-event request scans the tracks in use, parses each pending
// low-group-first delta, retires tracks that reach FF 2F, picks the earliest event in 32-bit
// modular time (lowest track on a tie) and decodes it as a channel message or a meta event.
// Every request gives exactly one result. A load writes a byte (and with the last-byte flag
// the track length), a rewind resets the tracks in use, and a next-event request reads the
// record, delta and up to 2 marker bytes of each track, then the event and size bytes, on one
// store read port, one byte per cycle; a request is taken once the last result is registered.
`include "multitrack_midi_event_merger_macros.svh"

module multitrack_midi_event_merger #(
    parameter int TRACKS      = 32,
    parameter int TRACK_BYTES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [4:0]  s_track_index,
    input  logic [11:0] s_byte_offset,
    input  logic [7:0]  s_byte_value,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_status,
    output logic [31:0] m_event_delta,
    output logic [7:0]  m_status_byte,
    output logic [7:0]  m_first_data,
    output logic [7:0]  m_second_data,
    output logic [11:0] m_meta_length,
    output logic [11:0] m_meta_offset,
    output logic [4:0]  m_event_track
);
    import mmem_pkg::*;

    localparam int TIW   = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int OW    = $clog2(TRACK_BYTES);
    localparam int LW    = OW + 1;
    localparam int AW    = TIW + OW;
    localparam int DEPTH = TRACKS * (2 ** OW);

    typedef struct packed {
        logic [LW-1:0] len;
        logic [LW-1:0] pos;
        logic [LW-1:0] rem;
        logic [31:0]   tm;
    } rec_t;

    // Control and datapath registers
    state_t        state_reg, state_next;
    logic [5:0]    num_tracks_reg;
    logic [31:0]   global_reg, global_next;
    logic [TIW-1:0] ridx_reg, ridx_next;
    logic [LW-1:0] ptr_reg, ptr_next;
    rec_t          cur_reg, cur_next;
    logic [LW-1:0] dn_reg, dn_next;
    logic [31:0]   dv_reg, dv_next;
    logic [5:0]    sh_reg, sh_next;
    logic          found_reg, found_next;
    logic [31:0]   best_reg, best_next;
    logic [TIW-1:0] bt_reg, bt_next;
    logic [LW-1:0] bgot_reg, bgot_next;
    logic [31:0]   bdv_reg, bdv_next;
    logic [LW-1:0] off_reg, off_next;
    logic [1:0]    rstat_reg, rstat_next;
    logic [31:0]   rdelta_reg, rdelta_next;
    logic [7:0]    rsb_reg, rsb_next;
    logic [7:0]    rd1_reg, rd1_next;
    logic [7:0]    rd2_reg, rd2_next;
    logic [11:0]   rmlen_reg, rmlen_next;
    logic [11:0]   rmoff_reg, rmoff_next;
    logic [4:0]    rtrk_reg, rtrk_next;
    logic          mv_reg;
    logic [TRACKS-1:0] rv_reg;

    // Memories
    logic [7:0]    store_mem [DEPTH];
    logic [7:0]    st_q;
    logic          st_we;
    logic [AW-1:0] st_waddr, st_raddr;
    rec_t          rec_mem [TRACKS];
    rec_t          rec_raw, rec_fwd_reg, rec_rd;
    logic          rec_fwd_hit_reg, rec_valid_q, rec_we;

    logic          accept, slot_free, inrange;
    logic [6:0]    ntr, trk7;
    logic [16:0]   off17;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign slot_free = !mv_reg || m_ready;
    assign ntr       = ({1'b0, num_tracks_reg} > 7'(TRACKS)) ? 7'(TRACKS) : {1'b0, num_tracks_reg};
    assign trk7      = {2'b00, s_track_index};
    assign off17     = {5'b0, s_byte_offset};
    assign inrange   = (trk7 < 7'(TRACKS)) && (off17 < 17'(TRACK_BYTES));
    assign st_we     = accept && (s_mode == MODE_LOAD) && inrange;
    assign st_waddr  = {trk7[TIW-1:0], off17[OW-1:0]};
    assign st_raddr  = {ridx_next, ptr_next[OW-1:0]};

    // Byte store: one write, one registered read
    always_ff @(posedge aclk) begin
        if (st_we) begin
            store_mem[st_waddr] <= s_byte_value;
        end
        st_q <= store_mem[st_raddr];
    end

    // Track table: read-modify-write with forwarding of a same-entry write
    always_ff @(posedge aclk) begin
        if (rec_we) begin
            rec_mem[ridx_reg] <= cur_next;
        end
        rec_raw         <= rec_mem[ridx_next];
        rec_fwd_reg     <= cur_next;
        rec_fwd_hit_reg <= rec_we && (ridx_reg == ridx_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rv_reg      <= '0;
            rec_valid_q <= 1'b0;
        end else begin
            if (rec_we) begin
                rv_reg[ridx_reg] <= 1'b1;
            end
            rec_valid_q <= rv_reg[ridx_next] || (rec_we && (ridx_reg == ridx_next));
        end
    end

    assign rec_rd = !rec_valid_q ? '0 : (rec_fwd_hit_reg ? rec_fwd_reg : rec_raw);

    // Shared decisions
    logic [7:0]    b;
    logic [LW-1:0] dn_inc;
    logic [31:0]   dv_delta, dv_cand, dr;
    logic [LW-1:0] dn_cand;
    logic [38:0]   size_wide;
    logic [31:0]   size_val;
    logic          dl_fail, dl_chk, ff_hit, eot_hit, cand, better, adv, more, found_now;
    logic [TIW-1:0] bt_now;
    logic [31:0]   tm_new;
    logic [LW-1:0] rem1;
    logic          sz_bad;
    logic [32:0]   sz_sum;

    assign b         = st_q;
    assign dn_inc    = dn_reg + 1'b1;
    assign dv_delta  = sh_reg[5] ? dv_reg : dv_reg + ({25'b0, b[6:0]} << sh_reg[4:0]);
    assign dl_fail   = !b[7] && (dn_inc == cur_reg.rem);
    assign dl_chk    = {1'b0, cur_reg.rem} > ({1'b0, dn_inc} + (LW+1)'(2));
    assign ff_hit    = (b == META_CMD);
    assign eot_hit   = (b == META_EOT);
    assign cand      = ((state_reg == ST_SC_DLT) && b[7] && !dl_chk)
                    || ((state_reg == ST_SC_FF) && !ff_hit)
                    || ((state_reg == ST_SC_EOT) && !eot_hit);
    assign dv_cand   = (state_reg == ST_SC_DLT) ? dv_delta : dv_reg;
    assign dn_cand   = (state_reg == ST_SC_DLT) ? dn_inc : dn_reg;
    assign dr        = dv_cand + cur_reg.tm - global_reg;
    assign better    = !found_reg || (dr < best_reg);
    assign adv       = ((state_reg == ST_SC_REC) && (rec_rd.rem == '0)) || cand
                    || ((state_reg == ST_SC_EOT) && eot_hit);
    assign more      = (7'(ridx_reg) + 7'd1) < ntr;
    assign found_now = found_reg || cand;
    assign bt_now    = (cand && better) ? ridx_reg : bt_reg;
    assign tm_new    = rec_rd.tm + bdv_reg;
    assign rem1      = rec_rd.rem - bgot_reg;
    assign size_wide = {dv_reg, b[6:0]};
    assign size_val  = (size_wide[38:32] != '0) ? 32'hFFFF_FFFF : size_wide[31:0];
    assign sz_sum    = 33'(dn_inc) + 33'(size_val);
    assign sz_bad    = 33'(cur_reg.rem) <= sz_sum;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_mode)
                        MODE_LOAD:   state_next = (inrange && s_last_byte) ? ST_LOAD_REC : ST_DONE;
                        MODE_NEXT:   state_next = (ntr == '0) ? ST_DONE : ST_SC_REC;
                        MODE_REWIND: state_next = (ntr == '0) ? ST_DONE : ST_REW_REC;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_LOAD_REC: state_next = ST_DONE;
            ST_REW_REC:  state_next = more ? ST_REW_REC : ST_DONE;
            ST_SC_REC, ST_SC_DLT, ST_SC_FF, ST_SC_EOT: begin
                if (adv) begin
                    state_next = more ? ST_SC_REC : (found_now ? ST_PK_REC : ST_DONE);
                end else if (state_reg == ST_SC_REC) begin
                    state_next = ST_SC_DLT;
                end else if (state_reg == ST_SC_DLT) begin
                    if (b[7]) begin
                        state_next = ST_SC_FF;
                    end else if (dl_fail) begin
                        state_next = ST_DONE;
                    end
                end else if (state_reg == ST_SC_FF) begin
                    state_next = ST_SC_EOT;
                end
            end
            ST_PK_REC: state_next = (rem1 < LW'(3)) ? ST_DONE : ST_PK_CMD;
            ST_PK_CMD: begin
                if (b < CHAN_CMD_MIN) begin
                    state_next = ST_DONE;
                end else if (b < SYSEX_CMD) begin
                    state_next = ST_PK_D1;
                end else if (b == META_CMD) begin
                    state_next = ST_PK_TYPE;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_PK_D1:   state_next = msg_two_data(rsb_reg) ? ST_PK_D2 : ST_DONE;
            ST_PK_D2:   state_next = ST_DONE;
            ST_PK_TYPE: state_next = (cur_reg.rem == LW'(1)) ? ST_DONE : ST_PK_SIZE;
            ST_PK_SIZE: begin
                if (!b[7] || (dn_inc == cur_reg.rem)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: state_next = slot_free ? ST_IDLE : ST_DONE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and table writes
    always_comb begin
        global_next = global_reg;
        ridx_next   = ridx_reg;
        ptr_next    = ptr_reg;
        cur_next    = cur_reg;
        dn_next     = dn_reg;
        dv_next     = dv_reg;
        sh_next     = sh_reg;
        found_next  = found_reg;
        best_next   = best_reg;
        bt_next     = bt_reg;
        bgot_next   = bgot_reg;
        bdv_next    = bdv_reg;
        off_next    = off_reg;
        rstat_next  = rstat_reg;
        rdelta_next = rdelta_reg;
        rsb_next    = rsb_reg;
        rd1_next    = rd1_reg;
        rd2_next    = rd2_reg;
        rmlen_next  = rmlen_reg;
        rmoff_next  = rmoff_reg;
        rtrk_next   = rtrk_reg;
        rec_we      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                // Open a request with a cleared result
                if (accept) begin
                    rstat_next  = RES_OK;
                    rdelta_next = '0;
                    rsb_next    = '0;
                    rd1_next    = '0;
                    rd2_next    = '0;
                    rmlen_next  = '0;
                    rmoff_next  = '0;
                    rtrk_next   = '0;
                    found_next  = 1'b0;
                    off_next    = off17[LW-1:0];
                    ridx_next   = (s_mode == MODE_LOAD) ? trk7[TIW-1:0] : '0;
                    if ((s_mode == MODE_NEXT) && (ntr == '0)) begin
                        rstat_next = RES_EOF;
                    end
                end
            end
            ST_LOAD_REC: begin
                cur_next     = rec_rd;
                cur_next.len = off_reg + 1'b1;
                rec_we       = 1'b1;
            end
            ST_REW_REC: begin
                cur_next     = rec_rd;
                cur_next.pos = '0;
                cur_next.rem = rec_rd.len;
                rec_we       = 1'b1;
                if (more) begin
                    ridx_next = ridx_reg + 1'b1;
                end
            end
            ST_SC_REC: begin
                cur_next = rec_rd;
                ptr_next = rec_rd.pos;
                dn_next  = '0;
                dv_next  = '0;
                sh_next  = '0;
            end
            ST_SC_DLT: begin
                // Accumulate one delta group
                dv_next  = dv_delta;
                dn_next  = dn_inc;
                sh_next  = sh_reg[5] ? sh_reg : sh_reg + 6'd7;
                ptr_next = ptr_reg + 1'b1;
                if (dl_fail) begin
                    rstat_next = RES_BAD;
                end
            end
            ST_SC_FF: begin
                ptr_next = ptr_reg + 1'b1;
            end
            ST_SC_EOT: begin
                // Retire a track at its end marker
                if (eot_hit) begin
                    cur_next.rem = '0;
                    rec_we       = 1'b1;
                end
            end
            ST_PK_REC: begin
                // Take the chosen delta into the times
                cur_next     = rec_rd;
                cur_next.tm  = tm_new;
                cur_next.rem = rem1;
                global_next  = tm_new;
                rdelta_next  = tm_new - global_reg;
                rtrk_next    = 5'(ridx_reg);
                if (rem1 < LW'(3)) begin
                    rec_we     = 1'b1;
                    rstat_next = RES_BAD;
                end else begin
                    cur_next.pos = rec_rd.pos + bgot_reg;
                    ptr_next     = rec_rd.pos + bgot_reg;
                end
            end
            ST_PK_CMD: begin
                rsb_next     = b;
                cur_next.pos = cur_reg.pos + 1'b1;
                cur_next.rem = cur_reg.rem - 1'b1;
                ptr_next     = ptr_reg + 1'b1;
                if ((b < CHAN_CMD_MIN) || ((b >= SYSEX_CMD) && (b != META_CMD))) begin
                    rec_we     = 1'b1;
                    rstat_next = RES_BAD;
                end
            end
            ST_PK_D1: begin
                rd1_next     = b;
                cur_next.pos = cur_reg.pos + 1'b1;
                cur_next.rem = cur_reg.rem - 1'b1;
                ptr_next     = ptr_reg + 1'b1;
                if (!msg_two_data(rsb_reg)) begin
                    rec_we = 1'b1;
                end
            end
            ST_PK_D2: begin
                rd2_next     = b;
                cur_next.pos = cur_reg.pos + 1'b1;
                cur_next.rem = cur_reg.rem - 1'b1;
                rec_we       = 1'b1;
            end
            ST_PK_TYPE: begin
                rd1_next     = b;
                cur_next.pos = cur_reg.pos + 1'b1;
                cur_next.rem = cur_reg.rem - 1'b1;
                ptr_next     = ptr_reg + 1'b1;
                dn_next      = '0;
                dv_next      = '0;
                if (cur_reg.rem == LW'(1)) begin
                    rec_we     = 1'b1;
                    rstat_next = RES_BAD;
                end
            end
            ST_PK_SIZE: begin
                // Accumulate one size group, saturating
                dv_next  = size_val;
                dn_next  = dn_inc;
                ptr_next = ptr_reg + 1'b1;
                if (!b[7]) begin
                    rec_we = 1'b1;
                    if (sz_bad) begin
                        rstat_next = RES_BAD;
                    end else begin
                        rmlen_next   = size_val[11:0];
                        rmoff_next   = 12'(cur_reg.pos + dn_inc);
                        cur_next.pos = cur_reg.pos + dn_inc + size_val[LW-1:0];
                        cur_next.rem = cur_reg.rem - dn_inc - size_val[LW-1:0];
                    end
                end else if (dn_inc == cur_reg.rem) begin
                    rec_we     = 1'b1;
                    rstat_next = RES_BAD;
                end
            end
            default: begin
            end
        endcase

        // Keep the earliest candidate and step to the next track
        if (cand && better) begin
            best_next = dr;
            bt_next   = ridx_reg;
            bgot_next = dn_cand;
            bdv_next  = dv_cand;
        end
        if (cand) begin
            found_next = 1'b1;
        end
        if (adv) begin
            if (more) begin
                ridx_next = ridx_reg + 1'b1;
            end else if (found_now) begin
                ridx_next = bt_now;
            end else begin
                rstat_next = RES_EOF;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            num_tracks_reg <= 6'd1;
            global_reg     <= '0;
            mv_reg         <= 1'b0;
        end else begin
            state_reg  <= state_next;
            global_reg <= global_next;
            if (cfg_wr_en) begin
                num_tracks_reg <= cfg_wr_data;
            end
            if ((state_reg == ST_DONE) && slot_free) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        ridx_reg   <= ridx_next;
        ptr_reg    <= ptr_next;
        cur_reg    <= cur_next;
        dn_reg     <= dn_next;
        dv_reg     <= dv_next;
        sh_reg     <= sh_next;
        found_reg  <= found_next;
        best_reg   <= best_next;
        bt_reg     <= bt_next;
        bgot_reg   <= bgot_next;
        bdv_reg    <= bdv_next;
        off_reg    <= off_next;
        rstat_reg  <= rstat_next;
        rdelta_reg <= rdelta_next;
        rsb_reg    <= rsb_next;
        rd1_reg    <= rd1_next;
        rd2_reg    <= rd2_next;
        rmlen_reg  <= rmlen_next;
        rmoff_reg  <= rmoff_next;
        rtrk_reg   <= rtrk_next;
    end

    // Output register: zero the payload of anything but a good event
    logic ok_res;
    assign ok_res = (rstat_reg == RES_OK);

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_DONE) && slot_free) begin
            m_result_status <= rstat_reg;
            m_event_delta   <= ok_res ? rdelta_reg : '0;
            m_status_byte   <= ok_res ? rsb_reg : '0;
            m_first_data    <= ok_res ? rd1_reg : '0;
            m_second_data   <= ok_res ? rd2_reg : '0;
            m_meta_length   <= ok_res ? rmlen_reg : '0;
            m_meta_offset   <= ok_res ? rmoff_reg : '0;
            m_event_track   <= ok_res ? rtrk_reg : '0;
        end
    end

    assign m_valid = mv_reg;

    `MMEM_ASSERT_NXT(a_req_leaves_idle, accept, state_reg != ST_IDLE)
    `MMEM_ASSERT_IMP(a_bad_zero, m_valid && (m_result_status != RES_OK), m_event_delta == '0 && m_event_track == '0)
    `MMEM_ASSERT_IMP(a_rec_idx, rec_we, 7'(ridx_reg) < 7'(TRACKS))
    `MMEM_ASSERT_NXT(a_result_loads, (state_reg == ST_DONE) && slot_free, m_valid)

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import mmem_pkg::*;

    localparam int NTRK = 32;
    localparam int NBYTES = 4096;
    localparam int ITEMS = 1950;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        bit          is_cfg;
        logic [5:0]  cfg;
        logic [1:0]  mode;
        logic [4:0]  trk;
        logic [11:0] off;
        logic [7:0]  val;
        logic        last;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] delta;
        logic [7:0]  cmd;
        logic [7:0]  d1;
        logic [7:0]  d2;
        logic [11:0] mlen;
        logic [11:0] moff;
        logic [4:0]  trk;
    } event_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [5:0]  cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode = '0;
    logic [4:0]  s_track_index = '0;
    logic [11:0] s_byte_offset = '0;
    logic [7:0]  s_byte_value = '0;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_result_status;
    logic [31:0] m_event_delta;
    logic [7:0]  m_status_byte;
    logic [7:0]  m_first_data;
    logic [7:0]  m_second_data;
    logic [11:0] m_meta_length;
    logic [11:0] m_meta_offset;
    logic [4:0]  m_event_track;

    multitrack_midi_event_merger dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_track_index(s_track_index), .s_byte_offset(s_byte_offset),
        .s_byte_value(s_byte_value), .s_last_byte(s_last_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_result_status(m_result_status),
        .m_event_delta(m_event_delta), .m_status_byte(m_status_byte),
        .m_first_data(m_first_data), .m_second_data(m_second_data),
        .m_meta_length(m_meta_length), .m_meta_offset(m_meta_offset),
        .m_event_track(m_event_track)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Predictor state: shadow of the track tables
    logic [7:0]  shadow_store [NTRK][NBYTES];
    logic [31:0] shadow_len [NTRK];
    logic [31:0] shadow_pos [NTRK];
    logic [31:0] shadow_rem [NTRK];
    logic [31:0] shadow_time [NTRK];
    logic [31:0] song_time;
    logic [5:0]  active_tracks;

    request_t pending_requests[$];
    event_t   expected_events[$];
    logic [7:0] track_bytes[$];

    int requests_sent = 0;
    int results_seen = 0;
    int loads_sent = 0, nexts_sent = 0, ok_events = 0, eof_events = 0, bad_events = 0;
    int failures = 0;
    int idle_cycles = 0;
    int sender_idle = 25, receiver_idle = 75;

    function automatic logic [7:0] peek(int t, logic [31:0] off);
        if (off >= NBYTES) return 8'h00;
        return shadow_store[t][off];
    endfunction

    // Low-group-first delta; returns bytes used, 0 without an end byte
    function automatic int read_delta(int t, logic [31:0] p, logic [31:0] left,
                                      output logic [31:0] v);
        int n;
        int sh;
        logic [7:0] b;
        n = 0; sh = 0; v = '0;
        while (n < left) begin
            b = peek(t, p + n);
            n++;
            if (sh < 32) v = v + ({25'd0, b[6:0]} << sh);
            if (b[7]) return n;
            if (sh < 32) sh += 7;
        end
        return 0;
    endfunction

    // Big-endian saturating size; returns bytes used, 0 without an end byte
    function automatic int read_size(int t, logic [31:0] p, logic [31:0] left,
                                     output logic [31:0] v);
        int n;
        logic [63:0] acc;
        logic [7:0] b;
        n = 0; acc = '0; v = '0;
        while (n < left) begin
            b = peek(t, p + n);
            n++;
            acc = (acc << 7) | {57'd0, b[6:0]};
            if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
            if (!b[7]) begin
                v = acc[31:0];
                return n;
            end
        end
        return 0;
    endfunction

    function automatic event_t status_only(logic [1:0] st);
        event_t e;
        e = '0;
        e.status = st;
        return e;
    endfunction

    // Merge step: pick the earliest pending event and decode it
    function automatic event_t merge_next();
        event_t e;
        int n, t, got;
        bit found;
        logic [31:0] d, best, p, len, left;
        logic [7:0] c;
        n = (active_tracks > NTRK) ? NTRK : active_tracks;
        found = 0; t = 0; best = '0;
        for (int i = 0; i < n; i++) begin
            if (shadow_rem[i] == 0) continue;
            got = read_delta(i, shadow_pos[i], shadow_rem[i], d);
            if (got == 0) return status_only(RES_BAD);
            p = shadow_pos[i] + got;
            if (shadow_rem[i] > got + 2 && peek(i, p) == META_CMD
                    && peek(i, p + 1) == META_EOT) begin
                shadow_rem[i] = 0;
                continue;
            end
            d = d + shadow_time[i] - song_time;
            if (!found || d < best) begin
                best = d; t = i; found = 1;
            end
        end
        if (!found) return status_only(RES_EOF);
        got = read_delta(t, shadow_pos[t], shadow_rem[t], d);
        shadow_time[t] += d;
        d = shadow_time[t] - song_time;
        song_time = shadow_time[t];
        shadow_rem[t] -= got;
        if (shadow_rem[t] < 3) return status_only(RES_BAD);
        shadow_pos[t] += got;
        e = '0;
        e.status = RES_OK;
        e.delta = d;
        e.trk = t[4:0];
        c = peek(t, shadow_pos[t]);
        shadow_pos[t]++; shadow_rem[t]--;
        e.cmd = c;
        if (c < CHAN_CMD_MIN) return status_only(RES_BAD);
        if (c < SYSEX_CMD) begin
            e.d1 = peek(t, shadow_pos[t]);
            shadow_pos[t]++; shadow_rem[t]--;
            if (c[7:4] != 4'hC && c[7:4] != 4'hD) begin
                e.d2 = peek(t, shadow_pos[t]);
                shadow_pos[t]++; shadow_rem[t]--;
            end
            return e;
        end
        if (c == META_CMD) begin
            e.d1 = peek(t, shadow_pos[t]);
            shadow_pos[t]++; shadow_rem[t]--;
            left = shadow_rem[t];
            got = read_size(t, shadow_pos[t], left, len);
            if (got == 0 || {32'd0, left} <= 64'(got) + {32'd0, len})
                return status_only(RES_BAD);
            e.mlen = len[11:0];
            e.moff = 12'(shadow_pos[t] + got);
            shadow_pos[t] += got + len;
            shadow_rem[t] -= got + len;
            return e;
        end
        return status_only(RES_BAD);
    endfunction

    function automatic event_t predict_request(request_t r);
        int n;
        case (r.mode)
            MODE_LOAD: begin
                shadow_store[r.trk][r.off] = r.val;
                if (r.last) shadow_len[r.trk] = 32'(r.off) + 1;
            end
            MODE_NEXT: return merge_next();
            MODE_REWIND: begin
                n = (active_tracks > NTRK) ? NTRK : active_tracks;
                for (int i = 0; i < n; i++) begin
                    shadow_pos[i] = '0;
                    shadow_rem[i] = shadow_len[i];
                end
            end
            default: ;
        endcase
        return status_only(RES_OK);
    endfunction

    // Stimulus builders
    function automatic void add_request(logic [1:0] m, int t = 0, int o = 0,
                                        int v = 0, bit l = 0);
        request_t r;
        r.is_cfg = 0; r.cfg = '0; r.mode = m; r.trk = t[4:0];
        r.off = o[11:0]; r.val = v[7:0]; r.last = l;
        pending_requests.push_back(r);
    endfunction

    function automatic void add_config(int v);
        request_t r;
        r = '{default: '0};
        r.is_cfg = 1; r.cfg = v[5:0];
        pending_requests.push_back(r);
    endfunction

    function automatic void push_delta(logic [31:0] v);
        while (v >= 128) begin
            track_bytes.push_back({1'b0, v[6:0]});
            v = v >> 7;
        end
        track_bytes.push_back({1'b1, v[6:0]});
    endfunction

    // Load every byte of the built track; the final one sets its length
    function automatic void load_track(int t);
        foreach (track_bytes[i])
            add_request(MODE_LOAD, t, i, track_bytes[i], i == track_bytes.size() - 1);
        track_bytes.delete();
    endfunction

    // Track with random content, now and then a bad event or a broken tail
    function automatic void build_track(int nev);
        int k, sz;
        logic [7:0] c;
        for (int e = 0; e < nev; e++) begin
            k = $urandom_range(99);
            if (k < 5) push_delta($urandom);
            else if (k < 30) push_delta($urandom_range(3));
            else push_delta($urandom_range(400));
            k = $urandom_range(99);
            if (k < 70) begin
                c = 8'h80 + 8'($urandom_range(111));
                track_bytes.push_back(c);
                track_bytes.push_back(8'($urandom_range(255)));
                if (c[7:4] != 4'hC && c[7:4] != 4'hD)
                    track_bytes.push_back(8'($urandom_range(255)));
            end else if (k < 88) begin
                sz = $urandom_range(5);
                track_bytes.push_back(META_CMD);
                track_bytes.push_back(8'($urandom_range(127)));
                if ($urandom_range(3) == 0) track_bytes.push_back(8'h80);
                track_bytes.push_back(8'(sz));
                repeat (sz) track_bytes.push_back(8'($urandom_range(255)));
            end else if (k < 93) begin
                track_bytes.push_back(8'hF0 + 8'($urandom_range(14)));
            end else if (k < 96) begin
                track_bytes.push_back(8'($urandom_range(127)));
            end else begin
                track_bytes.push_back(META_CMD);
                track_bytes.push_back(8'h01);
                track_bytes.push_back(8'hFF);
                track_bytes.push_back(8'h7F);
            end
        end
        k = $urandom_range(99);
        push_delta($urandom_range(50));
        if (k < 85) begin
            track_bytes.push_back(META_CMD);
            track_bytes.push_back(META_EOT);
            track_bytes.push_back(8'h00);
        end else if (k < 93) begin
            track_bytes.push_back(8'h90);
        end else begin
            track_bytes.push_back(8'h05);
        end
    endfunction

    // Driver: present pending requests, predict on acceptance
    always @(posedge aclk) begin
        request_t r;
        bit       drive_valid;
        bit       wr;
        bit       taken;
        if (!aresetn) begin
            s_valid <= 1'b0;
            cfg_wr_en <= 1'b0;
        end else begin
            taken = s_valid && s_ready;
            drive_valid = s_valid && !s_ready;
            wr = 0;
            if (taken) begin
                r = pending_requests.pop_front();
                expected_events.push_back(predict_request(r));
                requests_sent++;
                if (r.mode == MODE_LOAD) loads_sent++;
                if (r.mode == MODE_NEXT) nexts_sent++;
            end
            if (!drive_valid && pending_requests.size() > 0) begin
                r = pending_requests[0];
                if (r.is_cfg) begin
                    // Hold off until the block has returned every result
                    if (!taken && requests_sent == results_seen
                            && expected_events.size() == 0) begin
                        wr = 1;
                        cfg_wr_data <= r.cfg;
                        active_tracks = r.cfg;
                        void'(pending_requests.pop_front());
                    end
                end else if ($urandom_range(99) >= sender_idle) begin
                    drive_valid = 1;
                    s_mode <= r.mode;
                    s_track_index <= r.trk;
                    s_byte_offset <= r.off;
                    s_byte_value <= r.val;
                    s_last_byte <= r.last;
                end
            end
            s_valid <= drive_valid;
            cfg_wr_en <= wr;
            if (requests_sent < 650) begin
                sender_idle <= 25; receiver_idle <= 75;
            end else if (requests_sent < 1300) begin
                sender_idle <= 75; receiver_idle <= 25;
            end else begin
                sender_idle <= 0; receiver_idle <= 0;
            end
        end
    end

    // Monitor: compare each result with the oldest prediction
    always @(posedge aclk) begin
        event_t got, want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = '{m_result_status, m_event_delta, m_status_byte, m_first_data,
                        m_second_data, m_meta_length, m_meta_offset, m_event_track};
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, got);
                    failures++;
                end else begin
                    want = expected_events.pop_front();
                    if (got != want) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        failures++;
                    end
                    case (want.status)
                        RES_OK:  ok_events++;
                        RES_EOF: eof_events++;
                        default: bad_events++;
                    endcase
                end
                results_seen <= results_seen + 1;
            end
            if ((m_valid && m_ready) || (s_valid && s_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("CHECKS FAILED");
                $finish;
            end
            m_ready <= ($urandom_range(99) >= receiver_idle);
        end
    end

    initial begin
        int ntr, cfgv, phase_no, sz;
        foreach (shadow_len[i]) begin
            shadow_len[i] = '0; shadow_pos[i] = '0;
            shadow_rem[i] = '0; shadow_time[i] = '0;
        end
        song_time = '0;
        active_tracks = 6'd1;

        // Directed: note on, long delta, program change, meta, sysex, data as
        // command, meta size running past the end, control change, end of track
        track_bytes = '{8'h80, 8'h90, 8'h3C, 8'h7F,
                        8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h81, 8'hC0, 8'h05,
                        8'h83, 8'hFF, 8'h51, 8'h03, 8'h01, 8'h02, 8'h03,
                        8'h81, 8'hF0, 8'h81, 8'h3C,
                        8'h81, 8'hFF, 8'h01, 8'h85, 8'h00,
                        8'h80, 8'hB0, 8'h07, 8'h64, 8'h80, 8'hFF, 8'h2F, 8'h00};
        add_config(3);
        load_track(0);
        // Channel pressure then end of track; pitch bend then a short event
        track_bytes = '{8'h85, 8'hD0, 8'h40, 8'h80, 8'hFF, 8'h2F, 8'h00};
        load_track(1);
        track_bytes = '{8'h85, 8'hE0, 8'h00, 8'h7F, 8'h81, 8'h90};
        load_track(2);
        add_request(MODE_LOAD, 31, 4095, 8'hFF, 0);
        add_request(MODE_UNUSED, 31, 4095, 8'hFF, 1);
        add_request(MODE_REWIND);
        repeat (14) add_request(MODE_NEXT);
        add_config(0);
        add_request(MODE_NEXT);
        add_request(MODE_REWIND);

        // Random phases through several track counts, the extremes among them
        phase_no = 0;
        while (pending_requests.size() < ITEMS) begin
            case (phase_no)
                0: cfgv = 32;
                1: cfgv = 63;
                2: cfgv = 1;
                default: cfgv = $urandom_range(1, 8);
            endcase
            if (phase_no > 3 && $urandom_range(9) == 0) cfgv = $urandom_range(63);
            phase_no++;
            add_config(cfgv);
            ntr = (cfgv > NTRK) ? NTRK : cfgv;
            for (int t = 0; t < ntr; t++) begin
                if (ntr > 8 && phase_no > 2 && $urandom_range(1)) continue;
                build_track((ntr > 8) ? 1 : $urandom_range(1, 5));
                load_track(t);
            end
            add_request(MODE_REWIND);
            sz = (ntr > 8) ? ntr + 4 : 4 * ntr + 6;
            for (int k = 0; k < sz; k++) begin
                case ($urandom_range(29))
                    0: add_request(MODE_REWIND);
                    1: add_request(MODE_UNUSED, $urandom, $urandom, $urandom, $urandom);
                    default: add_request(MODE_NEXT);
                endcase
            end
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Drain, then allow the last result time to settle
        while (pending_requests.size() > 0 || s_valid || results_seen != requests_sent
                || expected_events.size() > 0) begin
            @(posedge aclk);
            #1;
        end
        repeat (40) @(posedge aclk);
        $display("Covered %0d requests (%0d loads, %0d next-event) over %0d phases",
                 requests_sent, loads_sent, nexts_sent, phase_no + 2);
        $display("Results: %0d events, %0d end of file, %0d invalid",
                 ok_events, eof_events, bad_events);
        if (failures == 0 && expected_events.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
